// ===== sv/mts_pkg.sv =====
// shared types and constants for the min tracking stack
`timescale 1ns / 1ps

package mts_pkg;

  // word width of stored values and default stack depth
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned DEPTH_DEFAULT = 256;

  // operation codes on the command port
  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_POP_EMPTY  = 2'd1,
    STATUS_PUSH_FULL  = 2'd2
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DONE
  } state_e;

  // one stored entry: value and running minimum up to it
  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic signed [WORD_W-1:0] min;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic exec;
    logic load;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pop_ok;
  } ctrl_stat_t;

endpackage

// ===== sv/mts_ctrl.sv =====
// controller state machine for the min tracking stack
`timescale 1ns / 1ps

module mts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  mts_pkg::ctrl_stat_t stat_i,
  output mts_pkg::ctrl_cmd_t  cmd_o,
  output logic                busy_o,
  output logic                done_o
);

  mts_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and command decode
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    done_o    = 1'b0;
    busy_o    = 1'b1;
    case (state_q)
      mts_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.exec = 1'b1;
          // a successful pop must fetch the entry below the top
          state_d    = stat_i.pop_ok ? mts_pkg::ST_LOAD : mts_pkg::ST_DONE;
        end
      end
      mts_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = mts_pkg::ST_DONE;
      end
      mts_pkg::ST_DONE: begin
        done_o  = 1'b1;
        state_d = mts_pkg::ST_IDLE;
      end
      default: begin
        state_d = mts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/mts_datapath.sv =====
// datapath: entry memory, top-of-stack registers and fill count
`timescale 1ns / 1ps

module mts_datapath #(
  parameter int unsigned DEPTH = mts_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mts_pkg::ctrl_cmd_t                  ctrl_i,
  output mts_pkg::ctrl_stat_t                 stat_o,
  input  logic                                cmd_i,
  input  logic signed [mts_pkg::WORD_W-1:0]   value_i,
  output logic signed [mts_pkg::WORD_W-1:0]   popped_value_o,
  output logic signed [mts_pkg::WORD_W-1:0]   current_min_o,
  output logic                                is_empty_o,
  output logic [1:0]                          status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // entries below the top; the top itself lives in registers
  mts_pkg::entry_t mem [DEPTH];
  mts_pkg::entry_t rd_q;

  logic [CW-1:0]                    fill_q;
  logic signed [mts_pkg::WORD_W-1:0] top_val_q;
  logic signed [mts_pkg::WORD_W-1:0] top_min_q;
  logic signed [mts_pkg::WORD_W-1:0] popped_q;
  mts_pkg::status_e                 status_q;

  logic          is_push;
  logic          empty;
  logic          full;
  logic          push_ok;
  logic          mem_wr;
  logic          mem_rd;
  logic [CW-1:0] fill_m1;
  logic [CW-1:0] fill_m2;
  logic signed [mts_pkg::WORD_W-1:0] new_min;

  // operation decode
  always_comb begin
    is_push       = (cmd_i == mts_pkg::CMD_PUSH);
    empty         = (fill_q == '0);
    full          = (fill_q == CW'(DEPTH));
    push_ok       = is_push && !full;
    stat_o.pop_ok = !is_push && !empty;
    fill_m1       = fill_q - CW'(1);
    fill_m2       = fill_q - CW'(2);
    // old top spills into memory when something is below the new one
    mem_wr        = ctrl_i.exec && push_ok && !empty;
    // fetch the new top when at least two entries are present
    mem_rd        = ctrl_i.exec && stat_o.pop_ok && (fill_q > CW'(1));
    new_min       = (!empty && (top_min_q < value_i)) ? top_min_q : value_i;
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem[fill_m1[AW-1:0]] <= '{value: top_val_q, min: top_min_q};
    end
    if (mem_rd) begin
      rd_q <= mem[fill_m2[AW-1:0]];
    end
  end

  // fill count and top minimum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      top_min_q <= '0;
    end else if (ctrl_i.exec) begin
      if (push_ok) begin
        fill_q    <= fill_q + CW'(1);
        top_min_q <= new_min;
      end else if (stat_o.pop_ok) begin
        fill_q <= fill_m1;
      end
    end else if (ctrl_i.load) begin
      top_min_q <= empty ? '0 : rd_q.min;
    end
  end

  // top value and result word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      popped_q <= '1;
      status_q <= mts_pkg::STATUS_OK;
      if (is_push) begin
        if (full) begin
          status_q <= mts_pkg::STATUS_PUSH_FULL;
        end else begin
          top_val_q <= value_i;
        end
      end else if (empty) begin
        status_q <= mts_pkg::STATUS_POP_EMPTY;
      end else begin
        popped_q <= top_val_q;
      end
    end else if (ctrl_i.load && !empty) begin
      top_val_q <= rd_q.value;
    end
  end

  // result outputs
  always_comb begin
    popped_value_o = popped_q;
    current_min_o  = empty ? '1 : top_min_q;
    is_empty_o     = empty;
    status_o       = status_q;
  end

endmodule

// ===== sv/min_tracking_stack_top.sv =====
// top level of the min tracking stack
`timescale 1ns / 1ps

// Stack of signed 32-bit words in which every entry also carries the minimum
// of the stack up to it. Raise start with cmd_i and value_i while busy is
// low; the word is taken on that clock edge and busy stays high until the
// result has been shown. A push, or a pop on an empty stack, shows its result
// in the cycle right after it is taken; a successful pop shows it after a load
// state, as the top entry sits in registers and the entry below it comes from
// the entry memory, with one write and one registered read port. The result
// is on the output ports for exactly one cycle with done_o high and cannot be
// held off, so the receiver must take it then. No clearing pass is needed
// after reset.
module min_tracking_stack_top #(
  parameter int unsigned DEPTH = mts_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd_i,
  input  logic signed [mts_pkg::WORD_W-1:0] value_i,
  output logic                              done_o,
  output logic signed [mts_pkg::WORD_W-1:0] popped_value_o,
  output logic signed [mts_pkg::WORD_W-1:0] current_min_o,
  output logic                              is_empty_o,
  output logic [1:0]                        status_o
);

  mts_pkg::ctrl_cmd_t  ctrl_cmd;
  mts_pkg::ctrl_stat_t ctrl_stat;

  // sequencing
  mts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (ctrl_stat),
    .cmd_o  (ctrl_cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  // storage and result
  mts_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl_cmd),
    .stat_o        (ctrl_stat),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .popped_value_o(popped_value_o),
    .current_min_o (current_min_o),
    .is_empty_o    (is_empty_o),
    .status_o      (status_o)
  );

endmodule
